### rtl/decoded_frame_window_bitmap_defines.svh
// assertion macros for the decoded frame window bitmap
`ifndef DECODED_FRAME_WINDOW_BITMAP_DEFINES_SVH
`define DECODED_FRAME_WINDOW_BITMAP_DEFINES_SVH

// same-cycle implication
`define DFWB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DFWB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dfwb_pkg.sv
// package: sizes, codes and types of the decoded frame window bitmap
package dfwb_pkg;

	localparam int WIN_DEPTH = 1024;
	localparam int LOG_W = $clog2(WIN_DEPTH);
	localparam int WORD_W = (WIN_DEPTH >= 64) ? WIN_DEPTH / 32 : 2;
	localparam int ROWS = WIN_DEPTH / WORD_W;
	localparam int LOG_WW = $clog2(WORD_W);
	localparam int LOG_ROWS = $clog2(ROWS);

	localparam int ID_W = 63;
	localparam int TS_W = 32;
	localparam int CMD_W = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SWEEP,
		ST_QUERY,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [ID_W-1:0] id;
		logic [TS_W-1:0] frame_timestamp;
	} request_t;

	typedef struct packed {
		logic [TS_W-1:0] last_timestamp;
		logic [ID_W-1:0] last_id;
		logic history_valid;
		logic status;
		logic was_decoded;
	} result_t;

	typedef struct packed {
		logic rd_en;
		logic [LOG_ROWS-1:0] rd_row;
		logic wr_en;
		logic [LOG_ROWS-1:0] wr_row;
		logic [WORD_W-1:0] wr_data;
	} mem_req_t;

endpackage

### rtl/dfwb_mem.sv
// bitmap word memory, one write and one registered read per cycle
module dfwb_mem (
	input logic clk,
	input dfwb_pkg::mem_req_t mem_req,
	output logic [dfwb_pkg::WORD_W-1:0] rd_data
);
	import dfwb_pkg::*;

	logic [WORD_W-1:0] mem_q [ROWS];
	logic [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem_q[mem_req.wr_row] <= mem_req.wr_data;
		end
		if (mem_req.rd_en) begin
			rd_data_q <= mem_q[mem_req.rd_row];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/dfwb_ctrl.sv
// command sequencer: window checks, row read-modify-write sweep, history registers
`include "decoded_frame_window_bitmap_defines.svh"

module dfwb_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input dfwb_pkg::request_t in_req,
	output logic res_valid,
	input logic res_ready,
	output dfwb_pkg::result_t res,
	output dfwb_pkg::mem_req_t mem_req,
	input logic [dfwb_pkg::WORD_W-1:0] rd_data
);
	import dfwb_pkg::*;

	state_t state_q, state_d;
	request_t req_q;
	logic [ID_W-1:0] newest_q, newest_d;
	logic have_q, have_d;
	logic [TS_W-1:0] ts_q, ts_d;
	logic [ROWS-1:0] row_valid_q, row_valid_d;
	logic status_q, status_d;
	logic answer_q, answer_d;
	logic [LOG_ROWS-1:0] rd_row_s1, rd_row_d;
	logic [LOG_ROWS-1:0] left_q, left_d;
	logic [LOG_W-1:0] jump_q, jump_d;

	logic [ID_W:0] sub_a, sub_b, diff;
	logic borrow, far, zero;
	logic [LOG_W-1:0] id_slot, new_slot;
	logic [LOG_ROWS-1:0] row_id, row_new, span;
	logic wrap_same;
	logic [WORD_W-1:0] old_word, new_word;

	assign id_slot = req_q.id[LOG_W-1:0];
	assign new_slot = newest_q[LOG_W-1:0];
	assign row_id = id_slot[LOG_W-1:LOG_WW];
	assign row_new = new_slot[LOG_W-1:LOG_WW];
	assign span = row_id - row_new;
	assign wrap_same = (row_id == row_new) && (id_slot < new_slot);

	assign sub_a = (req_q.cmd == CMD_INSERT) ? {1'b0, req_q.id} : {1'b0, newest_q};
	assign sub_b = (req_q.cmd == CMD_INSERT) ? {1'b0, newest_q} : {1'b0, req_q.id};
	assign diff = sub_a - sub_b;
	assign borrow = diff[ID_W];
	assign far = |diff[ID_W-1:LOG_W];
	assign zero = (diff == '0);

	// new contents of the row under sweep
	always_comb begin
		logic [LOG_W-1:0] p;
		logic [LOG_W-1:0] d;
		logic clr;
		old_word = row_valid_q[rd_row_s1] ? rd_data : '0;
		for (int b = 0; b < WORD_W; b++) begin
			p = {rd_row_s1, LOG_WW'(b)};
			d = p - new_slot;
			clr = (d != '0) && (d < jump_q);
			new_word[b] = (old_word[b] & ~clr) | (p == id_slot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			newest_q <= '0;
			have_q <= 1'b0;
			ts_q <= '0;
			row_valid_q <= '0;
			status_q <= 1'b0;
			answer_q <= 1'b0;
		end else begin
			state_q <= state_d;
			newest_q <= newest_d;
			have_q <= have_d;
			ts_q <= ts_d;
			row_valid_q <= row_valid_d;
			status_q <= status_d;
			answer_q <= answer_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_req;
		end
		rd_row_s1 <= rd_row_d;
		left_q <= left_d;
		jump_q <= jump_d;
	end

	always_comb begin
		state_d = state_q;
		newest_d = newest_q;
		have_d = have_q;
		ts_d = ts_q;
		row_valid_d = row_valid_q;
		status_d = status_q;
		answer_d = answer_q;
		rd_row_d = rd_row_s1;
		left_d = left_q;
		jump_d = jump_q;
		in_ready = 1'b0;
		res_valid = 1'b0;
		mem_req = '0;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					status_d = 1'b0;
					answer_d = 1'b0;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				case (req_q.cmd)
					CMD_INSERT: begin
						if (have_q && (borrow || zero)) begin
							status_d = 1'b1;
							state_d = ST_RESP;
						end else if (have_q && !far) begin
							rd_row_d = row_new;
							left_d = wrap_same ? LOG_ROWS'(ROWS - 1) : span;
							jump_d = diff[LOG_W-1:0];
							mem_req.rd_en = 1'b1;
							mem_req.rd_row = row_new;
							state_d = ST_SWEEP;
						end else begin
							if (have_q) begin
								row_valid_d = '0;
							end
							rd_row_d = row_id;
							left_d = '0;
							jump_d = '0;
							mem_req.rd_en = 1'b1;
							mem_req.rd_row = row_id;
							state_d = ST_SWEEP;
						end
					end
					CMD_QUERY: begin
						if (!have_q || borrow || far) begin
							state_d = ST_RESP;
						end else begin
							mem_req.rd_en = 1'b1;
							mem_req.rd_row = row_id;
							state_d = ST_QUERY;
						end
					end
					CMD_CLEAR: begin
						newest_d = '0;
						have_d = 1'b0;
						ts_d = '0;
						row_valid_d = '0;
						state_d = ST_RESP;
					end
					default: begin
						state_d = ST_RESP;
					end
				endcase
			end
			ST_SWEEP: begin
				mem_req.wr_en = 1'b1;
				mem_req.wr_row = rd_row_s1;
				mem_req.wr_data = new_word;
				row_valid_d[rd_row_s1] = 1'b1;
				if (left_q != '0) begin
					mem_req.rd_en = 1'b1;
					mem_req.rd_row = rd_row_s1 + 1'b1;
					rd_row_d = rd_row_s1 + 1'b1;
					left_d = left_q - 1'b1;
				end else begin
					newest_d = req_q.id;
					ts_d = req_q.frame_timestamp;
					have_d = 1'b1;
					state_d = ST_RESP;
				end
			end
			ST_QUERY: begin
				answer_d = row_valid_q[row_id] & rd_data[id_slot[LOG_WW-1:0]];
				state_d = ST_RESP;
			end
			ST_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res = '{
		last_timestamp: ts_q,
		last_id: newest_q,
		history_valid: have_q,
		status: status_q,
		was_decoded: answer_q
	};

	`DFWB_ASSERT_NOW(a_rmw_rows_differ, mem_req.wr_en && mem_req.rd_en,
		mem_req.wr_row != mem_req.rd_row, "sweep reads the row it writes")
	`DFWB_ASSERT_NOW(a_accept_not_busy, in_ready, !res_valid && !mem_req.wr_en,
		"transaction accepted while busy")
	`DFWB_ASSERT_NOW(a_reject_keeps_newest, res_valid && status_q, $stable(newest_q),
		"rejected insert moved the newest id")
	`DFWB_ASSERT_NOW(a_empty_history_zero, !have_q, newest_q == '0 && ts_q == '0,
		"empty history holds stale id or timestamp")

endmodule

### rtl/decoded_frame_window_bitmap.sv
// top level: decoded frame window bitmap with stream ports and output register
//
// channel  | direction | tdata (low bit up)                    | tuser
// s_axis   | in        | id[62:0], frame_timestamp[94:63]       | cmd[1:0]
// m_axis   | out       | was_decoded[0], status[1],             | -
//          |           | history_valid[2], last_id[65:3],       |
//          |           | last_timestamp[97:66]                  |
//
// one command at a time: clear, query outside the window and rejected insert
// pass decide then respond on the way to the output register, query inside the window
// adds a read step; insert sweeps the rows the skipped range spans
// (1 to 32 words of 32 bits), one read-modify-write per cycle on the bitmap ram
// reset and clear drop all the per-row valid bits together, no ram pass
// a held result in the output register stalls only the final step

module decoded_frame_window_bitmap (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [95:0] s_axis_tdata,  // id, frame_timestamp, zero pad
	input logic [1:0] s_axis_tuser,   // cmd
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [103:0] m_axis_tdata // was_decoded, status, history_valid,
	                                  // last_id, last_timestamp, zero pad
);
	import dfwb_pkg::*;

	request_t in_req;
	result_t res;
	logic res_valid, res_ready;
	mem_req_t mem_req;
	logic [WORD_W-1:0] rd_data;
	logic m_valid_q;
	result_t m_data_q;

	assign in_req = '{
		cmd: s_axis_tuser,
		id: s_axis_tdata[ID_W-1:0],
		frame_timestamp: s_axis_tdata[ID_W+TS_W-1:ID_W]
	};

	dfwb_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_req(in_req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.mem_req(mem_req),
		.rd_data(rd_data)
	);

	dfwb_mem u_mem (
		.clk(clk),
		.mem_req(mem_req),
		.rd_data(rd_data)
	);

	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_data_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {6'b0, m_data_q};

endmodule

### dv/decoded_frame_window_bitmap_tb.sv
// testbench for the decoded frame window bitmap: directed and random commands checked against a predictor
module decoded_frame_window_bitmap_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dfwb_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic STATUS_REJECTED = 1'b1;
	localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};
	localparam int RANDOM_ITEMS = 800;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 48;
	localparam int STALL_LIMIT = 2000;

	class frame_history_scoreboard;
		bit decoded [WIN_DEPTH];
		logic [ID_W-1:0] newest_id;
		logic [TS_W-1:0] newest_ts;
		logic have_newest;
		result_t pending[$];
		int failures;

		function new();
			failures = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (decoded[i])
				decoded[i] = 1'b0;
			newest_id = '0;
			newest_ts = '0;
			have_newest = 1'b0;
		endfunction

		function void note_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
				logic [TS_W-1:0] ts);
			result_t res;
			logic [ID_W-1:0] jump;
			logic [ID_W-1:0] pos;
			res = '0;
			case (cmd)
			CMD_INSERT: begin
				if (have_newest && id <= newest_id) begin
					res.status = STATUS_REJECTED;
				end else begin
					if (have_newest) begin
						jump = id - newest_id;
						if (jump >= WIN_DEPTH) begin
							wipe();
						end else begin
							// clear the slots the jump skipped over
							for (pos = newest_id + 1; pos != id; pos++)
								decoded[pos[LOG_W-1:0]] = 1'b0;
						end
					end
					decoded[id[LOG_W-1:0]] = 1'b1;
					newest_id = id;
					newest_ts = ts;
					have_newest = 1'b1;
				end
			end
			CMD_QUERY: begin
				res.was_decoded = have_newest && id <= newest_id
					&& (newest_id - id) < WIN_DEPTH && decoded[id[LOG_W-1:0]];
			end
			CMD_CLEAR: begin
				wipe();
			end
			default: begin
			end
			endcase
			res.history_valid = have_newest;
			res.last_id = newest_id;
			res.last_timestamp = newest_ts;
			pending.push_back(res);
		endfunction

		function void compare_field(string field, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0h actual %0h", field, want, got);
				failures++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$error("result with no pending command: %0h", got);
				failures++;
				return;
			end
			want = pending.pop_front();
			compare_field("was_decoded", want.was_decoded, got.was_decoded);
			compare_field("status", want.status, got.status);
			compare_field("history_valid", want.history_valid, got.history_valid);
			compare_field("last_id", want.last_id, got.last_id);
			compare_field("last_timestamp", want.last_timestamp, got.last_timestamp);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [103:0] m_axis_tdata;

	frame_history_scoreboard sb = new();

	bit calm = 1'b0;
	int holds_asked = 0;
	int holds_taken = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	logic [ID_W-1:0] gen_last = '0;
	bit gen_have = 1'b0;

	decoded_frame_window_bitmap DUT (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tuser,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_request(s_axis_tuser, s_axis_tdata[ID_W-1:0],
					s_axis_tdata[ID_W+TS_W-1:ID_W]);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// receiver: random backpressure plus a long hold-off on request
	always @(negedge clk) begin
		if (holds_taken != holds_asked) begin
			holds_taken++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= 14);
		end
	end

	task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
			input logic [TS_W-1:0] ts);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(99) < 14)
			gap = $urandom_range(6, 1);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, ts, id};
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic random_command();
		int pick;
		int sub;
		logic [ID_W-1:0] id;
		logic [ID_W-1:0] step;
		logic [TS_W-1:0] ts;
		pick = $urandom_range(99);
		sub = $urandom_range(99);
		ts = $urandom();
		id = ID_W'({$urandom(), $urandom()});
		if (pick < 50) begin
			if (gen_have) begin
				if (sub < 5) begin
					id = gen_last - ID_W'($urandom_range(20));
				end else begin
					if (sub < 70)
						step = ID_W'($urandom_range(4, 1));
					else if (sub < 88)
						step = ID_W'($urandom_range(200, 5));
					else if (sub < 96)
						step = ID_W'($urandom_range(1100, 900));
					else
						step = ID_W'($urandom()) + 1;
					id = gen_last + step;
					// id space exhausted, start over
					if (id <= gen_last) begin
						offer_command(CMD_CLEAR, id, ts);
						gen_have = 1'b0;
						return;
					end
				end
			end else if (sub < 50) begin
				id = ID_W'($urandom_range(3000));
			end else if (sub < 75) begin
				id = ID_MAX - ID_W'($urandom_range(3000));
			end
			offer_command(CMD_INSERT, id, ts);
			if (!gen_have || id > gen_last) begin
				gen_last = id;
				gen_have = 1'b1;
			end
		end else if (pick < 96) begin
			if (gen_have && sub < 80)
				id = gen_last - ID_W'($urandom_range(1100));
			else if (gen_have && sub < 90)
				id = gen_last + ID_W'($urandom_range(5, 1));
			offer_command(CMD_QUERY, id, ts);
		end else if (pick < 98) begin
			offer_command(CMD_CLEAR, id, ts);
			gen_have = 1'b0;
		end else begin
			offer_command(CMD_UNUSED, id, ts);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_INSERT;
		m_axis_tready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty history, rejection, skipped range, window edges, full wipe, top of id range
		offer_command(CMD_QUERY, '0, '0);
		offer_command(CMD_QUERY, ID_MAX, '1);
		offer_command(CMD_INSERT, '0, '0);
		offer_command(CMD_INSERT, '0, 32'd1);
		offer_command(CMD_QUERY, '0, '0);
		offer_command(CMD_INSERT, 63'd5, '1);
		offer_command(CMD_QUERY, 63'd3, '0);
		offer_command(CMD_QUERY, 63'd5, '0);
		offer_command(CMD_QUERY, 63'd6, '0);
		offer_command(CMD_INSERT, 63'd3, $urandom());
		offer_command(CMD_INSERT, 63'd1028, $urandom());
		offer_command(CMD_QUERY, 63'd5, '0);
		offer_command(CMD_QUERY, 63'd4, '0);
		offer_command(CMD_QUERY, 63'd1027, '0);
		offer_command(CMD_INSERT, 63'd2052, $urandom());
		offer_command(CMD_QUERY, 63'd1029, '0);
		offer_command(CMD_INSERT, ID_MAX, $urandom());
		offer_command(CMD_QUERY, ID_MAX, '0);
		offer_command(CMD_QUERY, ID_MAX - 63'd1023, '0);
		offer_command(CMD_UNUSED, ID_MAX, '1);
		offer_command(CMD_INSERT, ID_MAX, $urandom());
		offer_command(CMD_CLEAR, '0, '0);
		offer_command(CMD_QUERY, ID_MAX, '0);
		offer_command(CMD_INSERT, ID_MAX - 63'd1, $urandom());
		offer_command(CMD_CLEAR, ID_MAX, '1);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 250)
				holds_asked++;
			calm = (n >= 450 && n < 600);
			random_command();
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/dfwb_pkg.sv
rtl/dfwb_mem.sv
rtl/dfwb_ctrl.sv
rtl/decoded_frame_window_bitmap.sv
dv/decoded_frame_window_bitmap_tb.sv
